// File: rtl/acceptance_temperature_tuner_macros.svh
// ---------------------------------------------------------------------------
// Acceptance temperature tuner assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ACCEPTANCE_TEMPERATURE_TUNER_MACROS_SVH
`define ACCEPTANCE_TEMPERATURE_TUNER_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that holds at every clock edge out of reset.
`define ATT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that follows in the cycle after its trigger.
`define ATT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ATT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ATT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/att_pkg.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner package
// Shared types, register indexes, status codes and controller links.
// ---------------------------------------------------------------------------
package att_pkg;

    typedef logic [31:0] t_temp;     // Q16.16
    typedef logic [16:0] t_pct;      // Q1.16, up to 1.0
    typedef logic [15:0] t_factor;   // Q0.16
    typedef logic [23:0] t_runs;
    typedef logic [15:0] t_count;
    typedef logic [1:0]  t_status;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [31:0] t_cfg_data;

    localparam t_cfg_idx CfgStepInitial   = 3'd0;
    localparam t_cfg_idx CfgStepFactor    = 3'd1;
    localparam t_cfg_idx CfgStepMinimum   = 3'd2;
    localparam t_cfg_idx CfgPctLow        = 3'd3;
    localparam t_cfg_idx CfgPctHigh       = 3'd4;
    localparam t_cfg_idx CfgRunsBase      = 3'd5;
    localparam t_cfg_idx CfgRunsIncrement = 3'd6;
    localparam t_cfg_idx CfgRunsCeiling   = 3'd7;

    localparam t_status StatusContinue = 2'd0;
    localparam t_status StatusSettled  = 2'd1;
    localparam t_status StatusGaveUp   = 2'd2;

    localparam logic KindStart   = 1'b0;
    localparam logic KindMeasure = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_start;
        logic accept_measure;
        logic adjust;
        logic move;
        logic shrink;
        logic sub;
        logic div_init;
        logic div_step;
        logic calc;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over_band;
        logic below_band;
        logic temp_le_step;
        logic temp_lt_step;
    } t_sts;

endpackage

// File: rtl/att_if.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner channels
// Valid/ready interfaces for the item, result and configuration channels.
// ---------------------------------------------------------------------------
interface att_in_if;
    import att_pkg::*;
    logic  valid;
    logic  ready;
    logic  kind;
    t_temp start_temp;
    t_pct  measured_pct;
    modport source (output valid, kind, start_temp, measured_pct, input ready);
    modport sink   (input valid, kind, start_temp, measured_pct, output ready);
endinterface

interface att_out_if;
    import att_pkg::*;
    logic    valid;
    logic    ready;
    t_temp   run_temp;
    t_temp   end_temp;
    t_runs   run_length;
    t_status status;
    modport source (output valid, run_temp, end_temp, run_length, status, input ready);
    modport sink   (input valid, run_temp, end_temp, run_length, status, output ready);
endinterface

interface att_cfg_if;
    import att_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/acceptance_temperature_tuner.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner
// Steers a Monte Carlo temperature towards a target rejection band.
// ---------------------------------------------------------------------------
// The block takes one item at a time. A start beat loads the temperature and
// restarts the search; its result is written to the output register in the
// finish state, which directly follows acceptance. A measurement beat passes
// the adjust, move, divider set-up, divider, calc and finish states; below the
// band a subtract state follows the move, preceded by a shrink and a test state
// for each step shrink needed when a downward move would reach or pass zero
// (zero in the usual case). The end temperature is formed by multiplying
// with the reciprocal of one thousand in the divider states; the step
// shrink loop reuses a single 32 by 16 multiplier, one shrink and one compare
// per iteration, so a factor close to one with a large step can keep the block
// busy for a long time. The result sits in an output register, so the next
// item is accepted from the cycle after the previous result has been written
// there, whether or not it has yet been taken; a finished item whose result
// register still holds an untaken beat waits until that beat is taken.
// Configuration writes are always accepted and should only be issued while no
// item is in flight.
// ---------------------------------------------------------------------------
module acceptance_temperature_tuner (
    input logic        i_clk,
    input logic        i_rst_n,
    att_in_if.sink     i_in,
    att_out_if.source  o_out,
    att_cfg_if.sink    i_cfg
);
    import att_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Configuration beats never stall.
    assign i_cfg.ready = 1'b1;

    // Sequencer: accepts items, steps the datapath and holds result valid.
    att_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath: registers, multipliers, divider and the result register.
    att_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_start_temp   (i_in.start_temp),
        .i_measured_pct (i_in.measured_pct),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_run_temp     (o_out.run_temp),
        .o_end_temp     (o_out.end_temp),
        .o_run_length   (o_out.run_length),
        .o_status       (o_out.status)
    );

endmodule

// File: rtl/att_ctrl.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner controller
// Sequences one item at a time through the datapath and owns result valid.
// ---------------------------------------------------------------------------
`include "acceptance_temperature_tuner_macros.svh"

module att_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output att_pkg::t_cmd o_cmd,
    input  att_pkg::t_sts i_sts
);
    import att_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ADJUST = 10'b0000000010,
        S_MOVE   = 10'b0000000100,
        S_SHRINK = 10'b0000001000,
        S_TEST   = 10'b0000010000,
        S_SUB    = 10'b0000100000,
        S_DIVI   = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_CALC   = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KindStart) begin
                        cmd.accept_start = 1'b1;
                        n_state          = S_FINISH;
                    end else begin
                        cmd.accept_measure = 1'b1;
                        n_state            = S_ADJUST;
                    end
                end
            end
            S_ADJUST: begin
                cmd.adjust = 1'b1;
                n_state    = S_MOVE;
            end
            S_MOVE: begin
                cmd.move = 1'b1;
                if (i_sts.over_band) begin
                    n_state = S_DIVI;
                end else if (i_sts.below_band) begin
                    n_state = i_sts.temp_le_step ? S_SHRINK : S_SUB;
                end else begin
                    n_state = S_DIVI;
                end
            end
            S_SHRINK: begin
                cmd.shrink = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                n_state = i_sts.temp_lt_step ? S_SHRINK : S_SUB;
            end
            S_SUB: begin
                cmd.sub = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_state      = S_CALC;
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ATT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "item accepted but controller stayed idle")
    `ATT_ASSERT_ALWAYS(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "controller state is not one-hot")

endmodule

// File: rtl/att_dp.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner datapath
// Configuration, search state, shrink multiplier, reciprocal divider and result.
// ---------------------------------------------------------------------------
`include "acceptance_temperature_tuner_macros.svh"

module att_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  att_pkg::t_cfg_idx   i_cfg_index,
    input  att_pkg::t_cfg_data  i_cfg_data,
    input  att_pkg::t_temp      i_start_temp,
    input  att_pkg::t_pct       i_measured_pct,
    input  att_pkg::t_cmd       i_cmd,
    output att_pkg::t_sts       o_sts,
    output att_pkg::t_temp      o_run_temp,
    output att_pkg::t_temp      o_end_temp,
    output att_pkg::t_runs      o_run_length,
    output att_pkg::t_status    o_status
);
    import att_pkg::*;

    // ceil(2^38 / 1000); exact for every dividend up to 2^32 + 998, the largest formed here.
    localparam logic [28:0] DivRecip = 29'd274877907;

    // Configuration registers.
    t_temp   r_step_initial;
    t_factor r_step_factor;
    t_temp   r_step_minimum;
    t_pct    r_pct_low;
    t_pct    r_pct_high;
    t_runs   r_runs_base;
    t_runs   r_runs_inc;
    t_runs   r_runs_ceiling;

    // Search state.
    t_temp   r_temp;
    t_temp   r_step;
    logic    r_up;
    logic    r_down;
    t_count  r_count;
    t_runs   r_runs;
    t_pct    r_pct;
    t_status r_status;
    t_temp   r_end;
    logic [39:0] r_runs_prod;

    // Divide by one thousand: rounded-up dividend, then reciprocal product.
    logic [32:0] r_div_x;
    t_temp       r_div_q;

    // Result register.
    t_temp   r_out_temp;
    t_temp   r_out_end;
    t_runs   r_out_len;
    t_status r_out_status;

    logic [47:0] step_prod;
    t_temp       step_shrunk;
    logic [32:0] temp_sum;
    logic        over_band;
    logic        below_band;
    logic [61:0] div_prod;
    logic [40:0] runs_sum;
    logic [39:0] runs_mul;

    assign step_prod   = {16'b0, r_step} * {32'b0, r_step_factor};
    assign step_shrunk = step_prod[47:16];
    assign temp_sum    = {1'b0, r_temp} + {1'b0, r_step};
    assign over_band   = r_pct > r_pct_high;
    assign below_band  = r_pct < r_pct_low;
    assign div_prod    = {29'b0, r_div_x} * {33'b0, DivRecip};
    assign runs_mul    = {16'b0, r_runs_inc} * {24'b0, r_count};
    assign runs_sum    = {17'b0, r_runs_base} + {1'b0, r_runs_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_initial <= 32'd65536;
            r_step_factor  <= 16'd32768;
            r_step_minimum <= 32'd1;
            r_pct_low      <= 17'd19661;
            r_pct_high     <= 17'd32768;
            r_runs_base    <= 24'd1000;
            r_runs_inc     <= 24'd100;
            r_runs_ceiling <= 24'd10000;
            r_temp         <= '0;
            r_step         <= '0;
            r_up           <= 1'b0;
            r_down         <= 1'b0;
            r_count        <= '0;
            r_runs         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgStepInitial:   r_step_initial <= i_cfg_data;
                    CfgStepFactor:    r_step_factor  <= i_cfg_data[15:0];
                    CfgStepMinimum:   r_step_minimum <= i_cfg_data;
                    CfgPctLow:        r_pct_low      <= i_cfg_data[16:0];
                    CfgPctHigh:       r_pct_high     <= i_cfg_data[16:0];
                    CfgRunsBase:      r_runs_base    <= i_cfg_data[23:0];
                    CfgRunsIncrement: r_runs_inc     <= i_cfg_data[23:0];
                    CfgRunsCeiling:   r_runs_ceiling <= i_cfg_data[23:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.accept_start) begin
                r_temp  <= i_start_temp;
                r_step  <= r_step_initial;
                r_up    <= 1'b0;
                r_down  <= 1'b0;
                r_count <= '0;
                r_runs  <= r_runs_base;
            end

            if (i_cmd.accept_measure && (r_count != '1)) begin
                r_count <= r_count + 16'd1;
            end

            // Overshoot against the present direction narrows the search.
            if (i_cmd.adjust && ((r_down && over_band) || (r_up && below_band))) begin
                r_step <= step_shrunk;
            end

            if (i_cmd.move) begin
                if (over_band) begin
                    r_up   <= 1'b1;
                    r_down <= 1'b0;
                    r_temp <= temp_sum[32] ? '1 : temp_sum[31:0];
                end else if (below_band) begin
                    r_up   <= 1'b0;
                    r_down <= 1'b1;
                end else begin
                    r_up   <= 1'b0;
                    r_down <= 1'b0;
                end
            end

            if (i_cmd.shrink) begin
                r_step <= step_shrunk;
            end

            if (i_cmd.sub) begin
                r_temp <= r_temp - r_step;
            end

            if (i_cmd.calc && (r_runs < r_runs_ceiling)) begin
                r_runs <= (runs_sum > 41'hFFFFFF) ? '1 : runs_sum[23:0];
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_start) begin
            r_end    <= (i_start_temp != '0) ? i_start_temp - 32'd1 : '0;
            r_status <= StatusContinue;
        end
        if (i_cmd.accept_measure) begin
            r_pct    <= i_measured_pct;
            r_status <= StatusContinue;
        end
        if (i_cmd.move && !over_band && !below_band) begin
            r_status <= StatusSettled;
        end
        if (i_cmd.sub && (r_step < r_step_minimum)) begin
            r_status <= StatusGaveUp;
        end
        // ceil(temperature / 1000) is floor((temperature + 999) / 1000).
        if (i_cmd.div_init) begin
            r_div_x     <= {1'b0, r_temp} + 33'd999;
            r_runs_prod <= runs_mul;
        end
        if (i_cmd.div_step) begin
            r_div_q <= {8'b0, div_prod[61:38]};
        end
        // temperature * 0.999 floored equals temperature - ceil(temperature / 1000).
        if (i_cmd.calc) begin
            r_end <= r_temp - r_div_q;
        end
        if (i_cmd.load_out) begin
            r_out_temp   <= r_temp;
            r_out_end    <= r_end;
            r_out_len    <= r_runs;
            r_out_status <= r_status;
        end
    end

    assign o_sts.over_band    = over_band;
    assign o_sts.below_band   = below_band;
    assign o_sts.temp_le_step = r_temp <= r_step;
    assign o_sts.temp_lt_step = r_temp < r_step;

    assign o_run_temp   = r_out_temp;
    assign o_end_temp   = r_out_end;
    assign o_run_length = r_out_len;
    assign o_status     = r_out_status;

    `ATT_ASSERT_NEXT(a_quot_range, i_clk, i_rst_n, i_cmd.div_step, r_div_q <= 32'd4294968, "quotient exceeds the largest temperature over one thousand")
    `ATT_ASSERT_NEXT(a_shrink_no_grow, i_clk, i_rst_n, i_cmd.shrink, r_step <= $past(r_step), "step grew while shrinking")

endmodule

// File: sim/tb_acceptance_temperature_tuner.sv
// ---------------------------------------------------------------------------
// Acceptance temperature tuner testbench
// Drives start and measurement beats into the tuner, predicts every result
// with an in-bench model of the temperature search and compares each result
// beat field by field, across several register settings and idling regimes.
// ---------------------------------------------------------------------------
module tb_acceptance_temperature_tuner;
    timeunit 1ns;
    timeprecision 1ps;

    import att_pkg::*;

    // Twelve random phases of about 108 beats each, after the directed part.
    localparam int unsigned RandomPhases   = 12;
    localparam int unsigned BeatsPerPhase  = 108;
    // The receiver's long hold-off starts once this many beats have gone in.
    localparam int unsigned HoldOffAtBeat  = 150;
    localparam int unsigned HoldOffCycles  = 400;
    // The tail waits well beyond what a measurement outside the shrink loop needs.
    localparam int unsigned TailCycles     = 80;
    localparam longint unsigned CycleLimit = 64'd1_500_000;

    typedef struct packed {
        t_temp   run_temp;
        t_temp   end_temp;
        t_runs   run_length;
        t_status status;
    } t_run_setting;

    // Holds a private copy of the registers and of the search state, works out
    // the next run setting for every accepted beat and checks result beats
    // against those settings in order.
    class t_tuning_scoreboard;
        t_temp   step_init;
        t_factor step_mult;
        t_temp   step_floor;
        t_pct    band_low;
        t_pct    band_high;
        t_runs   runs_base;
        t_runs   runs_step;
        t_runs   runs_cap;

        t_temp   temp;
        t_temp   step;
        logic    rising;
        logic    falling;
        t_count  adjustments;
        t_runs   runs;

        t_run_setting expected_runs[$];

        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     starts;
        int unsigned     measures;
        int unsigned     settled;
        int unsigned     gave_up;
        longint unsigned shrink_total;

        function new();
            step_init    = 32'd65536;
            step_mult    = 16'd32768;
            step_floor   = 32'd1;
            band_low     = 17'd19661;
            band_high    = 17'd32768;
            runs_base    = 24'd1000;
            runs_step    = 24'd100;
            runs_cap     = 24'd10000;
            temp         = '0;
            step         = '0;
            rising       = 1'b0;
            falling      = 1'b0;
            adjustments  = '0;
            runs         = '0;
            mismatches   = 0;
            checked      = 0;
            starts       = 0;
            measures     = 0;
            settled      = 0;
            gave_up      = 0;
            shrink_total = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data d);
            case (idx)
                CfgStepInitial:   step_init  = d;
                CfgStepFactor:    step_mult  = d[15:0];
                CfgStepMinimum:   step_floor = d;
                CfgPctLow:        band_low   = d[16:0];
                CfgPctHigh:       band_high  = d[16:0];
                CfgRunsBase:      runs_base  = d[23:0];
                CfgRunsIncrement: runs_step  = d[23:0];
                CfgRunsCeiling:   runs_cap   = d[23:0];
                default: ;
            endcase
        endfunction

        // Q16.16 times Q0.16, truncated.
        function t_temp shrink_step(t_temp v);
            logic [47:0] product;
            product = {16'b0, v} * {32'b0, step_mult};
            return product[47:16];
        endfunction

        function void predict_run(logic kind, t_temp start_temp, t_pct pct);
            t_run_setting r;
            logic [32:0]  sum;
            logic [41:0]  scaled;
            logic [40:0]  runs_sum;
            r.status = StatusContinue;
            if (kind == KindStart) begin
                starts++;
                temp        = start_temp;
                step        = step_init;
                rising      = 1'b0;
                falling     = 1'b0;
                adjustments = '0;
                runs        = runs_base;
                // One LSB below the start, but never below zero.
                r.end_temp  = (start_temp != '0) ? start_temp - 32'd1 : '0;
            end else begin
                measures++;
                if (adjustments != 16'hFFFF) begin
                    adjustments++;
                end
                // Overshooting against the current direction shrinks the step by the factor.
                if ((falling && pct > band_high) || (rising && pct < band_low)) begin
                    step = shrink_step(step);
                end
                if (pct > band_high) begin
                    rising  = 1'b1;
                    falling = 1'b0;
                    sum     = {1'b0, temp} + {1'b0, step};
                    temp    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end else if (pct < band_low) begin
                    rising  = 1'b0;
                    falling = 1'b1;
                    // A move that would reach or pass zero shrinks the step first.
                    if (temp <= step) begin
                        do begin
                            step = shrink_step(step);
                            shrink_total++;
                        end while (temp < step);
                    end
                    temp = temp - step;
                    if (step < step_floor) begin
                        r.status = StatusGaveUp;
                    end
                end else begin
                    rising   = 1'b0;
                    falling  = 1'b0;
                    r.status = StatusSettled;
                end
                scaled     = {10'b0, temp} * 42'd999;
                scaled     = scaled / 42'd1000;
                r.end_temp = scaled[31:0];
                if (runs < runs_cap) begin
                    runs_sum = {17'b0, runs_base} +
                               {1'b0, ({16'b0, runs_step} * {24'b0, adjustments})};
                    runs     = (runs_sum > 41'hFF_FFFF) ? 24'hFF_FFFF : runs_sum[23:0];
                end
                if (r.status == StatusSettled) begin
                    settled++;
                end
                if (r.status == StatusGaveUp) begin
                    gave_up++;
                end
            end
            r.run_temp   = temp;
            r.run_length = runs;
            expected_runs.push_back(r);
        endfunction

        function void check_run(t_run_setting got);
            t_run_setting want;
            if (expected_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result beat with nothing expected: temp %h end %h runs %h st %0d",
                             $realtime, got.run_temp, got.end_temp, got.run_length, got.status);
                end
                return;
            end
            want = expected_runs.pop_front();
            checked++;
            if (got.run_temp !== want.run_temp || got.end_temp !== want.end_temp ||
                got.run_length !== want.run_length || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: run setting %0d differs", $realtime, checked);
                    $display("    expected temp %h end %h runs %h status %0d",
                             want.run_temp, want.end_temp, want.run_length, want.status);
                    $display("    got      temp %h end %h runs %h status %0d",
                             got.run_temp, got.end_temp, got.run_length, got.status);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    att_in_if  in_ch ();
    att_out_if out_ch ();
    att_cfg_if cfg_ch ();

    acceptance_temperature_tuner uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_tuning_scoreboard sb = new();

    // Idling probabilities in percent, changed by the stimulus as it goes.
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     beats_sent;
    int unsigned     cfg_writes;
    int unsigned     hold_left;
    bit              hold_done;
    longint unsigned cycle_count;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off once the sender
    // has pushed enough beats. During the hold-off the output register stays
    // full, the block finishes the beat in hand and then refuses new ones.
    always @(negedge clk) begin
        if (!hold_done && beats_sent >= HoldOffAtBeat) begin
            hold_left = HoldOffCycles;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result beat is checked at the edge at which it is taken.
    always @(posedge clk) begin : result_monitor
        t_run_setting got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.run_temp   = out_ch.run_temp;
            got.end_temp   = out_ch.end_temp;
            got.run_length = out_ch.run_length;
            got.status     = out_ch.status;
            sb.check_run(got);
        end
    end

    // The limit grows with the shrink iterations predicted so far, as each
    // adds a shrink and a test state to the work of the block.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit + 4 * sb.shrink_total) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, sb.expected_runs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one item beat, after a random gap, and holds it until taken.
    // The beat is noted in the scoreboard at the edge that accepts it.
    task automatic send_beat(logic kind, t_temp start_temp, t_pct pct);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.start_temp   <= start_temp;
        in_ch.measured_pct <= pct;
        do @(posedge clk); while (!in_ch.ready);
        sb.predict_run(kind, start_temp, pct);
        beats_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drops valid and waits until every predicted result beat has been taken,
    // so that the block is idle afterwards.
    task automatic await_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.expected_runs.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(t_temp si, t_factor f, t_temp sm, t_pct lo, t_pct hi,
                                  t_runs rb, t_runs ri, t_runs rc);
        write_reg(CfgStepInitial,   si);
        write_reg(CfgStepFactor,    {16'd0, f});
        write_reg(CfgStepMinimum,   sm);
        write_reg(CfgPctLow,        {15'd0, lo});
        write_reg(CfgPctHigh,       {15'd0, hi});
        write_reg(CfgRunsBase,      {8'd0, rb});
        write_reg(CfgRunsIncrement, {8'd0, ri});
        write_reg(CfgRunsCeiling,   {8'd0, rc});
    endtask

    // Random register set for one phase. A factor close to one is only paired
    // with a small initial step, since the shrink loop then removes little of the
    // step per iteration and would otherwise run for a very long time.
    task automatic random_settings();
        t_factor f;
        t_temp   si;
        t_temp   sm;
        t_pct    lo;
        t_pct    hi;
        t_runs   rb;
        t_runs   ri;
        t_runs   rc;
        case ($urandom_range(5))
            0:       f = 16'd1;
            1:       f = 16'hFFFF;
            default: f = t_factor'($urandom_range(8192, 60000));
        endcase
        if (f > 16'd60000) begin
            si = $urandom_range(1, 1024);
        end else begin
            case ($urandom_range(3))
                0:       si = 32'hFFFF_FFFF;
                1:       si = $urandom;
                default: si = $urandom_range(256, 32'h0040_0000);
            endcase
        end
        case ($urandom_range(4))
            0:       sm = '0;
            1:       sm = $urandom;
            default: sm = $urandom_range(0, 64);
        endcase
        case ($urandom_range(5))
            0: begin
                lo = '0;
                hi = 17'd65536;
            end
            1: begin
                // Inverted band: the above-band test wins where they overlap.
                lo = t_pct'($urandom_range(30000, 65536));
                hi = t_pct'($urandom_range(0, 29999));
            end
            default: begin
                lo = t_pct'($urandom_range(0, 45000));
                hi = lo + t_pct'($urandom_range(0, 20000));
            end
        endcase
        case ($urandom_range(4))
            0:       rb = '0;
            1:       rb = 24'hFF_FFFF;
            default: rb = t_runs'($urandom_range(0, 20000));
        endcase
        case ($urandom_range(4))
            0:       ri = '0;
            1:       ri = 24'hFF_FFFF;
            default: ri = t_runs'($urandom_range(0, 500));
        endcase
        case ($urandom_range(4))
            0:       rc = '0;
            1:       rc = 24'hFF_FFFF;
            default: rc = t_runs'($urandom_range(0, 30000));
        endcase
        apply_settings(si, f, sm, lo, hi, rb, ri, rc);
    endtask

    // Mostly aims at one of the three regions of the current band; the rest
    // is spread over the whole range with the ends favoured.
    function automatic t_pct pick_pct();
        int unsigned lo;
        int unsigned hi;
        lo = {15'd0, sb.band_low};
        hi = {15'd0, sb.band_high};
        if ($urandom_range(9) < 8) begin
            case ($urandom_range(2))
                0: if (hi < 65536) return t_pct'($urandom_range(hi + 1, 65536));
                1: if (lo > 0) return t_pct'($urandom_range(0, lo - 1));
                default: if (lo <= hi) return t_pct'($urandom_range(lo, hi));
            endcase
        end
        case ($urandom_range(3))
            0:       return '0;
            1:       return 17'd65536;
            default: return t_pct'($urandom_range(0, 65536));
        endcase
    endfunction

    // Start temperatures near the step reach the shrink loop and give-ups.
    function automatic t_temp pick_start_temp();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(0, 64);
            2:       return $urandom_range(0, sb.step_init);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned phase_beats;
        int unsigned seq_len;

        in_ch.valid         = 1'b0;
        in_ch.kind          = KindStart;
        in_ch.start_temp    = '0;
        in_ch.measured_pct  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CfgStepInitial;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        rst_n               = 1'b0;
        beats_sent          = 0;
        cfg_writes          = 0;
        hold_left           = 0;
        hold_done           = 1'b0;
        // First regime: the sender idles a little, the receiver a lot.
        send_idle_pct       = 22;
        recv_idle_pct       = 52;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, on the reset registers. A measurement before any
        // start works on the zero state: below the band it gives up at once.
        send_beat(KindMeasure, $urandom, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd65536);
        // Start at zero floors the end temperature; start at full scale and
        // then push up to hit the saturating add.
        send_beat(KindStart, 32'd0, t_pct'($urandom_range(0, 65536)));
        send_beat(KindStart, 32'hFFFF_FFFF, t_pct'($urandom_range(0, 65536)));
        send_beat(KindMeasure, 32'd0, 17'd65536);
        // Reversal below the band shrinks the step before moving down.
        send_beat(KindMeasure, 32'hFFFF_FFFF, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd25000);
        // Both edges of the band count as inside it.
        send_beat(KindMeasure, $urandom, 17'd19661);
        send_beat(KindMeasure, $urandom, 17'd32768);
        // One LSB of temperature: the step shrinks repeatedly down to the
        // temperature, then to zero, which ends in giving up.
        send_beat(KindStart, 32'd1, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd0);
        await_results();

        // Registers at or near the top, with an inverted band and saturating runs.
        apply_settings(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 17'd65536, 17'd0,
                       24'hFF_FFFE, 24'hFF_FFFF, 24'hFF_FFFF);
        send_beat(KindStart, 32'hFFFF_FFFF, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd65536);
        send_beat(KindMeasure, $urandom, 17'd0);
        send_beat(KindStart, 32'd5, 17'd1);
        send_beat(KindMeasure, $urandom, 17'd1);
        await_results();

        // A zero factor collapses the step on its first shrink; zero run
        // registers keep the run length frozen at zero.
        apply_settings(32'd1000, 16'd0, 32'd1, 17'd19661, 17'd32768, 24'd0, 24'd0, 24'd0);
        send_beat(KindStart, 32'd100000, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd0);
        send_beat(KindMeasure, $urandom, 17'd65536);
        send_beat(KindMeasure, $urandom, 17'd0);
        await_results();

        // Random phases: each writes a fresh register set, then runs start
        // beats followed by measurement sequences, with the odd stray start.
        for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
            if (phase == RandomPhases / 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 22;
            end else if (phase == 2 * RandomPhases / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_settings();
            phase_beats = 0;
            while (phase_beats < BeatsPerPhase) begin
                send_beat(KindStart, pick_start_temp(), t_pct'($urandom_range(0, 65536)));
                phase_beats++;
                seq_len = $urandom_range(1, 14);
                repeat (seq_len) begin
                    if ($urandom_range(19) == 0) begin
                        send_beat(KindStart, $urandom, pick_pct());
                    end else begin
                        send_beat(KindMeasure, $urandom, pick_pct());
                    end
                    phase_beats++;
                end
            end
            await_results();
        end

        // Any stray result beat in the tail is caught by the monitor.
        repeat (TailCycles) @(posedge clk);

        $display("covered %0d start and %0d measurement beats over %0d register writes",
                 sb.starts, sb.measures, cfg_writes);
        $display("settled %0d times, gave up %0d times, %0d step shrinks in the loop",
                 sb.settled, sb.gave_up, sb.shrink_total);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d of %0d result beats were wrong", sb.mismatches, sb.checked);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/att_pkg.sv
rtl/att_if.sv
rtl/att_ctrl.sv
rtl/att_dp.sv
rtl/acceptance_temperature_tuner.sv
sim/tb_acceptance_temperature_tuner.sv
